// ===== design/lcrd_pkg.sv =====
// Shared types and constants for the largest color run direction core.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lcrd_pkg;

  // Row geometry: four camera rows side by side form one panoramic row
  localparam int CAMERA_WIDTH = 64;
  localparam int CAMERA_COUNT = 4;
  localparam int ROW_LEN      = CAMERA_WIDTH * CAMERA_COUNT;

  localparam int COLOR_W = 8;
  localparam int IDX_W   = $clog2(ROW_LEN);
  localparam int LEN_W   = IDX_W + 1;

  // Heading divider: quotient of (center * 2^17 + L) / (2 * L)
  localparam int QUO_W     = 17;
  localparam int DIV_REM_W = LEN_W + 1;
  localparam int DIV_STEPS = QUO_W;

  // Heading as a fraction of a full turn of 65536
  localparam int HEAD_W      = 17;
  localparam int HEAD_OFFSET = 8192;
  localparam int HEAD_HALF   = 32768;
  localparam int HEAD_TURN   = 65536;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_RED   = 2'd0,
    REG_TARGET_GREEN = 2'd1,
    REG_TARGET_BLUE  = 2'd2
  } cfg_reg_t;

  // Run tracker state frozen at the end of a row
  typedef struct packed {
    logic             last_open;
    logic [1:0]       runs_seen;
    logic [IDX_W-1:0] open_start;
    logic [IDX_W-1:0] first_start;
    logic [LEN_W-1:0] first_length;
    logic [IDX_W-1:0] best_start;
    logic [LEN_W-1:0] best_length;
    logic [LEN_W-1:0] len_row;
  } row_sum_t;

  // Chosen run of a row
  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] run_len;
    logic [IDX_W-1:0] center;
    logic [LEN_W-1:0] len_row;
  } win_t;

  // One step of the heading divider
  typedef struct packed {
    logic                 found;
    logic [LEN_W-1:0]     run_len;
    logic [IDX_W-1:0]     center;
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_REM_W-1:0] divisor;
    logic [QUO_W-1:0]     dividend;
    logic [QUO_W-1:0]     quo;
  } div_stage_t;

endpackage

// ===== design/lcrd_scan.sv =====
// Target color registers, per-pixel run tracker and row summary register.
// Depends on lcrd_pkg.
`timescale 1ns / 1ps

module lcrd_scan (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lcrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcrd_pkg::COLOR_W-1:0]    cfg_data,
  input  logic [lcrd_pkg::COLOR_W-1:0]    red,
  input  logic [lcrd_pkg::COLOR_W-1:0]    green,
  input  logic [lcrd_pkg::COLOR_W-1:0]    blue,
  input  logic                            last_pixel,
  input  logic                            accept,
  input  logic                            adv,
  output logic                            sum_valid,
  output lcrd_pkg::row_sum_t              sum
);

  logic [lcrd_pkg::COLOR_W-1:0] target_red;
  logic [lcrd_pkg::COLOR_W-1:0] target_green;
  logic [lcrd_pkg::COLOR_W-1:0] target_blue;

  logic [lcrd_pkg::IDX_W-1:0] pixel_count;
  logic                       in_run;
  logic [lcrd_pkg::IDX_W-1:0] open_start;
  logic [1:0]                 runs_seen;
  logic [lcrd_pkg::IDX_W-1:0] first_start;
  logic [lcrd_pkg::LEN_W-1:0] first_length;
  logic [lcrd_pkg::IDX_W-1:0] best_start;
  logic [lcrd_pkg::LEN_W-1:0] best_length;

  logic                       in_run_next;
  logic [lcrd_pkg::IDX_W-1:0] open_start_next;
  logic [1:0]                 runs_seen_next;
  logic [lcrd_pkg::IDX_W-1:0] first_start_next;
  logic [lcrd_pkg::LEN_W-1:0] first_length_next;
  logic [lcrd_pkg::IDX_W-1:0] best_start_next;
  logic [lcrd_pkg::LEN_W-1:0] best_length_next;

  logic                       match;
  logic                       closing;
  logic                       row_end;
  logic [lcrd_pkg::LEN_W-1:0] close_len;
  logic                       sum_load;

  // Decode configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      target_red   <= '0;
      target_green <= '0;
      target_blue  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lcrd_pkg::REG_TARGET_RED:   target_red   <= cfg_data;
        lcrd_pkg::REG_TARGET_GREEN: target_green <= cfg_data;
        lcrd_pkg::REG_TARGET_BLUE:  target_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Track runs: open on a match, close on the first mismatch
  always_comb begin
    match   = (red == target_red) && (green == target_green) && (blue == target_blue);
    closing = in_run && !match;
    row_end = last_pixel || (pixel_count == lcrd_pkg::IDX_W'(lcrd_pkg::ROW_LEN - 1));
    close_len = {1'b0, pixel_count} - {1'b0, open_start};

    in_run_next       = match;
    open_start_next   = (match && !in_run) ? pixel_count : open_start;
    runs_seen_next    = runs_seen;
    first_start_next  = first_start;
    first_length_next = first_length;
    best_start_next   = best_start;
    best_length_next  = best_length;

    if (closing) begin
      if (runs_seen == 2'd0) begin
        first_start_next  = open_start;
        first_length_next = close_len;
        runs_seen_next    = 2'd1;
      end else begin
        // later run wins on equal length
        if (runs_seen == 2'd1 || close_len >= best_length) begin
          best_start_next  = open_start;
          best_length_next = close_len;
        end
        runs_seen_next = 2'd2;
      end
    end
  end

  // Advance tracker state; clear it after the row's last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count  <= '0;
      in_run       <= 1'b0;
      open_start   <= '0;
      runs_seen    <= 2'd0;
      first_start  <= '0;
      first_length <= '0;
      best_start   <= '0;
      best_length  <= '0;
    end else if (accept) begin
      if (row_end) begin
        pixel_count  <= '0;
        in_run       <= 1'b0;
        open_start   <= '0;
        runs_seen    <= 2'd0;
        first_start  <= '0;
        first_length <= '0;
        best_start   <= '0;
        best_length  <= '0;
      end else begin
        pixel_count  <= pixel_count + 1'b1;
        in_run       <= in_run_next;
        open_start   <= open_start_next;
        runs_seen    <= runs_seen_next;
        first_start  <= first_start_next;
        first_length <= first_length_next;
        best_start   <= best_start_next;
        best_length  <= best_length_next;
      end
    end
  end

  // Row summary register: loads when empty or when the pipe moves
  assign sum_load = adv || !sum_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sum_load) begin
      sum_valid <= accept && row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_load && accept && row_end) begin
      sum.last_open    <= in_run_next;
      sum.runs_seen    <= runs_seen_next;
      sum.open_start   <= open_start_next;
      sum.first_start  <= first_start_next;
      sum.first_length <= first_length_next;
      sum.best_start   <= best_start_next;
      sum.best_length  <= best_length_next;
      sum.len_row      <= {1'b0, pixel_count} + 1'b1;
    end
  end

endmodule

// ===== design/lcrd_select.sv =====
// Picks the longest run of a row, joins runs across the wrap, finds its center.
// Depends on lcrd_pkg.
`timescale 1ns / 1ps

module lcrd_select (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               sum_valid,
  input  lcrd_pkg::row_sum_t sum,
  output logic               win_valid,
  output lcrd_pkg::win_t     win
);

  logic                       joined;
  logic                       found;
  logic [lcrd_pkg::LEN_W-1:0] open_len;
  logic [lcrd_pkg::IDX_W-1:0] win_start;
  logic [lcrd_pkg::LEN_W-1:0] win_len;
  logic [lcrd_pkg::LEN_W:0]   center_sum;
  logic [lcrd_pkg::LEN_W:0]   center_mod;

  // Choose the window: wrap join first, then the later and longer runs
  always_comb begin
    joined   = sum.last_open && (sum.runs_seen != 2'd0) && (sum.first_start == '0);
    found    = (sum.runs_seen != 2'd0) || sum.last_open;
    open_len = sum.len_row - {1'b0, sum.open_start};
    win_start = '0;
    win_len   = '0;

    if (joined) begin
      win_start = sum.open_start;
      win_len   = sum.first_length + open_len;
      if (sum.runs_seen == 2'd2 && sum.best_length >= win_len) begin
        win_start = sum.best_start;
        win_len   = sum.best_length;
      end
    end else if (found) begin
      if (sum.runs_seen != 2'd0) begin
        win_start = sum.first_start;
        win_len   = sum.first_length;
      end
      if (sum.runs_seen == 2'd2 && sum.best_length >= win_len) begin
        win_start = sum.best_start;
        win_len   = sum.best_length;
      end
      if (sum.last_open && open_len >= win_len) begin
        win_start = sum.open_start;
        win_len   = open_len;
      end
    end

    // start plus half length stays below twice the row length
    center_sum = {2'b00, win_start} + {2'b00, win_len[lcrd_pkg::LEN_W-1:1]};
    center_mod = (center_sum >= {1'b0, sum.len_row})
               ? center_sum - {1'b0, sum.len_row} : center_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= 1'b0;
    end else if (adv) begin
      win_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win.found   <= found;
      win.run_len <= win_len;
      win.center  <= center_mod[lcrd_pkg::IDX_W-1:0];
      win.len_row <= sum.len_row;
    end
  end

endmodule

// ===== design/lcrd_div.sv =====
// Pipelined restoring divider for the heading, one quotient bit per stage.
// Depends on lcrd_pkg.
`timescale 1ns / 1ps

module lcrd_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 win_valid,
  input  lcrd_pkg::win_t       win,
  output logic                 quo_valid,
  output lcrd_pkg::div_stage_t quo_data
);

  localparam int RW = lcrd_pkg::DIV_REM_W;
  localparam int QW = lcrd_pkg::QUO_W;

  logic                 stage_valid [lcrd_pkg::DIV_STEPS];
  lcrd_pkg::div_stage_t stage_data  [lcrd_pkg::DIV_STEPS];
  lcrd_pkg::div_stage_t init;

  // Shift in one dividend bit, subtract the divisor where it fits
  function automatic lcrd_pkg::div_stage_t div_step(input lcrd_pkg::div_stage_t s);
    logic [RW:0]          trial;
    logic [RW:0]          diff;
    lcrd_pkg::div_stage_t r;
    r     = s;
    trial = {s.rem, s.dividend[QW-1]};
    diff  = trial - {1'b0, s.divisor};
    if (trial >= {1'b0, s.divisor}) begin
      r.rem = diff[RW-1:0];
      r.quo = {s.quo[QW-2:0], 1'b1};
    end else begin
      r.rem = trial[RW-1:0];
      r.quo = {s.quo[QW-2:0], 1'b0};
    end
    r.dividend = {s.dividend[QW-2:0], 1'b0};
    return r;
  endfunction

  // Dividend is center * 2^17 + L: center seeds the remainder, L is shifted in
  always_comb begin
    init.found    = win.found;
    init.run_len  = win.run_len;
    init.center   = win.center;
    init.rem      = RW'(win.center);
    init.divisor  = {win.len_row, 1'b0};
    init.dividend = QW'(win.len_row);
    init.quo      = '0;
  end

  for (genvar i = 0; i < lcrd_pkg::DIV_STEPS; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[i] <= 1'b0;
        end else if (adv) begin
          stage_valid[i] <= win_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stage_data[i] <= div_step(init);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[i] <= 1'b0;
        end else if (adv) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stage_data[i] <= div_step(stage_data[i-1]);
        end
      end
    end
  end

  assign quo_valid = stage_valid[lcrd_pkg::DIV_STEPS-1];
  assign quo_data  = stage_data[lcrd_pkg::DIV_STEPS-1];

endmodule

// ===== design/largest_color_run_direction_core.sv =====
// Top level of the largest color run direction core: handshakes and result register.
// Depends on lcrd_pkg, lcrd_scan, lcrd_select and lcrd_div.
`timescale 1ns / 1ps

// Takes one pixel of a panoramic row per cycle, back to back, and finds the
// longest run of the target color, with a run that touches both row ends
// joined across the wrap. One result beat follows each row: after the row's
// last pixel is taken, it passes through the row summary register, the run
// choice and center register, the heading divider stages (one quotient bit
// per stage) and the result register. The divider is pipelined, so rows as
// short as one pixel still go at one pixel per cycle. While a result waits
// under stall the whole pipe holds; pixels are still taken until the row
// summary register is occupied.
module largest_color_run_direction_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lcrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcrd_pkg::COLOR_W-1:0]        cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [lcrd_pkg::COLOR_W-1:0]        red,
  input  logic [lcrd_pkg::COLOR_W-1:0]        green,
  input  logic [lcrd_pkg::COLOR_W-1:0]        blue,
  input  logic                                last_pixel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                found,
  output logic [lcrd_pkg::LEN_W-1:0]          run_length,
  output logic [lcrd_pkg::IDX_W-1:0]          center_index,
  output logic signed [lcrd_pkg::HEAD_W-1:0]  heading
);

  localparam int HW = lcrd_pkg::HEAD_W + 1;

  logic                 adv;
  logic                 accept;
  logic                 sum_valid;
  lcrd_pkg::row_sum_t   sum;
  logic                 win_valid;
  lcrd_pkg::win_t       win;
  logic                 quo_valid;
  lcrd_pkg::div_stage_t quo_data;
  logic signed [HW-1:0] head_raw;
  logic signed [HW-1:0] head_wrap;

  // Move the pipe whenever the result register is free or being taken
  assign adv         = !result_valid || !result_stall;
  assign pixel_stall = sum_valid && !adv;
  assign accept      = pixel_valid && !pixel_stall;

  lcrd_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last_pixel (last_pixel),
    .accept     (accept),
    .adv        (adv),
    .sum_valid  (sum_valid),
    .sum        (sum)
  );

  lcrd_select u_select (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .sum_valid (sum_valid),
    .sum       (sum),
    .win_valid (win_valid),
    .win       (win)
  );

  lcrd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .win_valid (win_valid),
    .win       (win),
    .quo_valid (quo_valid),
    .quo_data  (quo_data)
  );

  // Shift the quotient so that zero is the front, then fold into half a turn
  always_comb begin
    head_raw  = $signed({1'b0, quo_data.quo}) - HW'(lcrd_pkg::HEAD_OFFSET);
    head_wrap = (head_raw > HW'(lcrd_pkg::HEAD_HALF))
              ? head_raw - HW'(lcrd_pkg::HEAD_TURN) : head_raw;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found        <= quo_data.found;
      run_length   <= quo_data.run_len;
      center_index <= quo_data.center;
      heading      <= quo_data.found ? head_wrap[lcrd_pkg::HEAD_W-1:0] : '0;
    end
  end

  // A row without a run reports all zeros
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> run_length == '0 && center_index == '0 && heading == '0)
    else $error("empty row result carries nonzero fields");

  // A found run has at least one pixel
  assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> run_length != '0)
    else $error("found run with zero length");

  // Heading stays within half a turn either way
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> heading >= -17'sd32767 && heading <= 17'sd32768)
    else $error("heading out of range");

endmodule
